[hdl/tli_pkg.sv]
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared constants, types and the divider step function.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int POINTS      = 5;
  localparam int CFG_REGS    = 5;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int VAL_W       = 32;
  localparam int H_STEP      = 1600000;
  localparam int T_STEP      = 1600;
  localparam int STEPS       = VAL_W;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [VAL_W-1:0]        u;
    logic [VAL_W-1:0]        d;
    logic [VAL_W-1:0]        mag;
    logic                    neg;
    logic signed [VAL_W-1:0] y0;
  } job_t;

  typedef struct packed {
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] q;
  } div_t;

  // One shift-and-add step of floor(u * m / d), kept with r < d.
  function automatic div_t div_step(div_t cur, logic [VAL_W-1:0] d,
                                    logic [VAL_W-1:0] u, logic mbit);
    logic [VAL_W+1:0] t;
    logic [VAL_W-1:0] q;
    div_t             res;
    t = {1'b0, cur.r, 1'b0};
    q = {cur.q[VAL_W-2:0], 1'b0};
    if (t >= {2'b00, d}) begin
      t = t - {2'b00, d};
      q = q + VAL_W'(1);
    end
    if (mbit) begin
      t = t + {2'b00, u};
      if (t >= {2'b00, d}) begin
        t = t - {2'b00, d};
        q = q + VAL_W'(1);
      end
    end
    res.r = t[VAL_W-1:0];
    res.q = q;
    return res;
  endfunction

endpackage

[hdl/tli_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying the direction and the sample.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [tli_pkg::VAL_W-1:0]   sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink (input valid, input action, input sample, output ready);
endinterface

[hdl/tli_out_if.sv]
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying the converted value.
// ----------------------------------------------------------------------------
interface tli_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tli_pkg::VAL_W-1:0]   converted;

  modport source (output valid, output converted, input ready);
  modport sink (input valid, input converted, output ready);
endinterface

[hdl/table_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// Table linear interpolator
// Converts a sample between enthalpy and temperature through a breakpoint
// table, clamping outside the table and interpolating linearly inside it.
//
// The input channel carries the direction (action) and a signed Q27.4
// sample; the output channel carries the converted Q27.4 value. A beat is
// taken whenever valid and ready are high together. The block takes one
// beat per cycle while the receiver does not stall: the front end registers
// the chosen segment, a two-entry queue follows, and the back end is a
// 32-stage multiply-divide pipeline that settles one quotient bit per
// stage, then a result register. When the receiver stalls, the divider
// pipeline holds, the queue fills and then the input ready drops; no beat
// is lost. Reset empties the pipeline and the queue and loads breakpoint k
// with enthalpy (k+1)*100000.0 and temperature (k+1)*100.0. The user must
// write breakpoints through the config port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
  parameter int POINTS = tli_pkg::POINTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tli_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tli_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  tli_in_if.sink                             in_i,
  tli_out_if.source                          out_o
);

  logic [tli_pkg::CFG_DATA_W-1:0] point_q [POINTS];
  logic                           job_valid, job_ready;
  logic                           head_valid, head_ready;
  tli_pkg::job_t                  job, head;

  for (genvar k = 0; k < POINTS; k++) begin : g_point
    localparam logic [31:0] HRST = 32'((k + 1) * tli_pkg::H_STEP);
    localparam logic [31:0] TRST = 32'((k + 1) * tli_pkg::T_STEP);

    if (k < tli_pkg::CFG_REGS) begin : g_wr
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          point_q[k] <= {HRST, TRST};
        end else if (cfg_we_i && cfg_index_i == tli_pkg::CFG_IDX_W'(k)) begin
          point_q[k] <= cfg_data_i;
        end
      end
    end else begin : g_fixed
      assign point_q[k] = {HRST, TRST};
    end
  end

  tli_front #(
    .POINTS(POINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .table_i    (point_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .action_i   (in_i.action),
    .sample_i   (in_i.sample),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  tli_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_valid),
    .push_ready_o(job_ready),
    .push_data_i (job),
    .pop_valid_o (head_valid),
    .pop_ready_i (head_ready),
    .pop_data_o  (head)
  );

  tli_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_ready_o(head_ready),
    .job_i      (head),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .converted_o(out_o.converted)
  );

endmodule

[hdl/tli_front.sv]
// ----------------------------------------------------------------------------
// Interpolator front end
// Selects the segment or clamp for a sample and forms the divider job.
// ----------------------------------------------------------------------------
module tli_front #(
  parameter int POINTS = tli_pkg::POINTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [tli_pkg::CFG_DATA_W-1:0]    table_i [POINTS],
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic signed [tli_pkg::VAL_W-1:0]  sample_i,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output tli_pkg::job_t                     job_o
);

  localparam int W = tli_pkg::VAL_W;

  logic signed [W-1:0] xs [POINTS];
  logic signed [W-1:0] ys [POINTS];
  logic [POINTS-1:0]   below;
  logic                valid_q;
  tli_pkg::job_t       job_q, job_d;

  always_comb begin
    for (int k = 0; k < POINTS; k++) begin
      xs[k]    = action_i ? table_i[k][W-1:0] : table_i[k][2*W-1:W];
      ys[k]    = action_i ? table_i[k][2*W-1:W] : table_i[k][W-1:0];
      below[k] = sample_i < xs[k];
    end
  end

  always_comb begin
    logic signed [W:0] dy;
    logic              found;
    job_d     = '0;
    job_d.d   = W'(1);
    found     = 1'b0;
    dy        = '0;
    if (below[0]) begin
      job_d.y0 = ys[0];
    end else if (!below[POINTS-1]) begin
      job_d.y0 = ys[POINTS-1];
    end else begin
      for (int k = 1; k < POINTS; k++) begin
        if (!found && below[k]) begin
          found     = 1'b1;
          job_d.u   = W'(sample_i - xs[k-1]);
          job_d.d   = W'(xs[k] - xs[k-1]);
          dy        = (W+1)'(ys[k]) - (W+1)'(ys[k-1]);
          job_d.neg = dy[W];
          job_d.mag = dy[W] ? W'(-dy) : W'(dy);
          job_d.y0  = ys[k-1];
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

[hdl/tli_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
module tli_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tli_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tli_pkg::job_t pop_data_o
);

  localparam int D   = tli_pkg::QUEUE_DEPTH;
  localparam int PW  = $clog2(D);

  tli_pkg::job_t  mem_q [D];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;
  logic           push, pop;

  assign push_ready_o = cnt_q < (PW+1)'(D);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(D-1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(D-1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[hdl/tli_back.sv]
// ----------------------------------------------------------------------------
// Interpolator back end
// Pipelined multiply-divide, one quotient bit per stage, and result register.
// ----------------------------------------------------------------------------
module tli_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  tli_pkg::job_t                     job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tli_pkg::VAL_W-1:0]  converted_o
);

  localparam int W = tli_pkg::VAL_W;
  localparam int S = tli_pkg::STEPS;

  logic                 v_q   [S];
  tli_pkg::job_t        job_q [S];
  tli_pkg::div_t        div_q [S];
  logic                 out_valid_q;
  logic signed [W-1:0]  converted_q;
  logic                 en;

  assign en          = !out_valid_q || out_ready_i;
  assign job_ready_o = en;
  assign out_valid_o = out_valid_q;
  assign converted_o = converted_q;

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic          v_in;
    tli_pkg::job_t j_in;
    tli_pkg::div_t d_in;

    if (s == 0) begin : g_first
      assign v_in = job_valid_i;
      assign j_in = job_i;
      assign d_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign j_in = job_q[s-1];
      assign d_in = div_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        job_q[s] <= j_in;
        div_q[s] <= tli_pkg::div_step(d_in, j_in.d, j_in.u, j_in.mag[S-1-s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[S-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      converted_q <= job_q[S-1].neg ? job_q[S-1].y0 - $signed(div_q[S-1].q)
                                    : job_q[S-1].y0 + $signed(div_q[S-1].q);
    end
  end

endmodule

[tb/sv/table_linear_interpolator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator checker
// Watches the configuration port and both channels, keeps its own copy of
// the breakpoint table, predicts the converted value of every input beat
// and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module table_linear_interpolator_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tli_in_if                              in_mon,
  tli_out_if                             out_mon,
  output int                             fail_count_o,
  output int                             pending_o
);

  logic [tli_pkg::CFG_DATA_W-1:0] breakpoints [tli_pkg::POINTS];
  logic signed [tli_pkg::VAL_W-1:0] expected_values [$];

  function automatic logic signed [tli_pkg::VAL_W-1:0] interpolate(
      logic act, logic signed [tli_pkg::VAL_W-1:0] x);
    longint xs [tli_pkg::POINTS];
    longint ys [tli_pkg::POINTS];
    longint hv, tv, u, d, dy, mag, q, res;
    logic [127:0] prod;
    logic found;
    res = 0;
    found = 1'b0;
    for (int k = 0; k < tli_pkg::POINTS; k++) begin
      hv = longint'($signed(breakpoints[k][63:32]));
      tv = longint'($signed(breakpoints[k][31:0]));
      xs[k] = act ? tv : hv;
      ys[k] = act ? hv : tv;
    end
    if (longint'(x) < xs[0]) begin
      res = ys[0];
    end else if (longint'(x) >= xs[tli_pkg::POINTS-1]) begin
      res = ys[tli_pkg::POINTS-1];
    end else begin
      for (int k = 1; k < tli_pkg::POINTS; k++) begin
        if (!found && longint'(x) < xs[k]) begin
          found = 1'b1;
          u = longint'(x) - xs[k-1];
          d = xs[k] - xs[k-1];
          dy = ys[k] - ys[k-1];
          mag = (dy < 0) ? -dy : dy;
          prod = 128'(u) * 128'(mag);
          q = longint'(prod / 128'(d));
          res = (dy < 0) ? ys[k-1] - q : ys[k-1] + q;
        end
      end
    end
    return res[tli_pkg::VAL_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tli_pkg::POINTS; k++) begin
        breakpoints[k] = {32'((k + 1) * tli_pkg::H_STEP), 32'((k + 1) * tli_pkg::T_STEP)};
      end
      expected_values.delete();
    end else begin
      if (cfg_we_i && cfg_index_i < tli_pkg::CFG_REGS && cfg_index_i < tli_pkg::POINTS) begin
        breakpoints[cfg_index_i] = cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_values.push_back(interpolate(in_mon.action, in_mon.sample));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected output beat, actual %0d", $time, out_mon.converted);
          fail_count_o++;
        end else begin
          if (out_mon.converted !== expected_values[0]) begin
            $display("%0t: converted mismatch, expected %0d actual %0d", $time,
                     expected_values[0], out_mon.converted);
            fail_count_o++;
          end
          void'(expected_values.pop_front());
        end
      end
    end
    pending_o = expected_values.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end
endmodule

[tb/sv/table_linear_interpolator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator testbench
// Loads a series of breakpoint tables, from the reset table to extreme,
// decreasing, unordered and flat ones, and streams directed and random
// samples in both directions with random gaps on both channels.
// ----------------------------------------------------------------------------
module table_linear_interpolator_tb;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data_i;
  int                             fail_count;
  int                             pending;
  int                             ready_hold;

  logic signed [tli_pkg::VAL_W-1:0] h_keys [tli_pkg::POINTS];
  logic signed [tli_pkg::VAL_W-1:0] t_keys [tli_pkg::POINTS];

  tli_in_if  in_if ();
  tli_out_if out_if ();

  table_linear_interpolator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  table_linear_interpolator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
        out_if.ready <= 1'b1;
        ready_hold <= $urandom_range(30, 1);
      end else if (r < 92) begin
        out_if.ready <= 1'b0;
        ready_hold <= $urandom_range(3, 1);
      end else begin
        out_if.ready <= 1'b0;
        ready_hold <= $urandom_range(80, 20);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  task automatic send_sample(logic act, logic signed [tli_pkg::VAL_W-1:0] value);
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.sample <= value;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(99);
    n = (r < 60) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(60, 20);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_point(int idx, logic [tli_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= tli_pkg::CFG_IDX_W'(idx);
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic load_table();
    for (int k = 0; k < tli_pkg::POINTS; k++) begin
      write_point(k, {h_keys[k], t_keys[k]});
    end
    write_point(tli_pkg::POINTS, {$urandom, $urandom});
    write_point(255, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic sort_keys(ref logic signed [tli_pkg::VAL_W-1:0] keys [tli_pkg::POINTS]);
    logic signed [tli_pkg::VAL_W-1:0] tmp;
    for (int i = 0; i < tli_pkg::POINTS; i++) begin
      for (int j = 0; j < tli_pkg::POINTS - 1 - i; j++) begin
        if (keys[j] > keys[j+1]) begin
          tmp = keys[j];
          keys[j] = keys[j+1];
          keys[j+1] = tmp;
        end
      end
    end
  endtask

  function automatic logic signed [tli_pkg::VAL_W-1:0] pick_sample(logic act);
    int r, k;
    longint lo, hi;
    logic [63:0] span;
    r = $urandom_range(99);
    k = $urandom_range(tli_pkg::POINTS - 1);
    lo = act ? t_keys[k] : h_keys[k];
    if (r < 25) begin
      return $urandom;
    end else if (r < 50) begin
      return tli_pkg::VAL_W'(lo + $urandom_range(6) - 3);
    end else begin
      hi = act ? t_keys[(k + 1) % tli_pkg::POINTS] : h_keys[(k + 1) % tli_pkg::POINTS];
      if (hi < lo) begin
        span = 64'(lo - hi);
        lo = hi;
      end else begin
        span = 64'(hi - lo);
      end
      return tli_pkg::VAL_W'(lo + longint'((span * 64'($urandom)) >> 32));
    end
  endfunction

  task automatic random_phase(int count);
    logic act;
    for (int n = 0; n < count; n++) begin
      act = $urandom_range(1);
      send_sample(act, pick_sample(act));
      idle_gap();
      if (n == count / 2 && $urandom_range(1)) drain();
    end
    drain();
  endtask

  task automatic directed_phase();
    logic signed [tli_pkg::VAL_W-1:0] mid;
    for (int a = 0; a < 2; a++) begin
      send_sample(a[0], 32'sh8000_0000);
      send_sample(a[0], 32'sh7FFF_FFFF);
      for (int k = 0; k < tli_pkg::POINTS; k++) begin
        send_sample(a[0], a[0] ? t_keys[k] : h_keys[k]);
        idle_gap();
      end
      for (int k = 0; k < tli_pkg::POINTS - 2; k++) begin
        mid = a[0] ? (t_keys[k] + t_keys[k+1]) / 2 : (h_keys[k] + h_keys[k+1]) / 2;
        send_sample(a[0], mid - 1);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.action = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    ready_hold   = 0;
    for (int k = 0; k < tli_pkg::POINTS; k++) begin
      h_keys[k] = (k + 1) * tli_pkg::H_STEP;
      t_keys[k] = (k + 1) * tli_pkg::T_STEP;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed_phase();
    random_phase(100);

    h_keys = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sh7FFF_FFFF};
    t_keys = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0};
    load_table();
    directed_phase();
    random_phase(80);

    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < tli_pkg::POINTS; k++) begin
        h_keys[k] = $urandom;
        t_keys[k] = $urandom;
      end
      if (p != 3) sort_keys(h_keys);
      if (p == 0 || p == 4) sort_keys(t_keys);
      if (p == 2) begin
        for (int k = 0; k < tli_pkg::POINTS; k++) t_keys[k] = -h_keys[k] / 16;
      end
      if (p == 1) begin
        for (int k = 0; k < tli_pkg::POINTS; k++) begin
          h_keys[k] = h_keys[0];
          t_keys[k] = t_keys[0];
        end
      end
      load_table();
      random_phase(100);
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
